[rtl/assert_macros.svh]
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, ignored while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked while rst is high.
`define ASSERT_CLK_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ihh_pkg.sv]
`default_nettype none

package ihh_pkg;

  localparam int NUM_SIDES_DEF   = 2;
  localparam int NUM_PLANES_DEF  = 5;
  localparam int NUM_PADDLES_DEF = 11;
  localparam int NUM_BINS_DEF    = 100;
  localparam int TIME_BITS_DEF   = 20;

  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int SIDE_W     = 1;
  localparam int PLANE_W    = 3;
  localparam int PADDLE_W   = 8;
  localparam int COUNT_W    = 32;
  localparam int SCALE_W    = 16;
  localparam int SCALE_SHIFT = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_USER_W  = OP_W + 1;
  localparam int OUT_USER_W = STATUS_W;
  localparam int OUT_QUEUE_DEPTH = 8;

  localparam logic [SCALE_W-1:0] TDC_SCALE_RESET = 16'd640;
  localparam logic [SCALE_W-1:0] ADC_SCALE_RESET = 16'd819;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_HIT       = 2'd0,
    OP_END_EVENT = 2'd1,
    OP_READ      = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EVENT_END   = 3'd0,
    ST_BAD_CHANNEL = 3'd1,
    ST_FIRST_HIT   = 3'd2,
    ST_BINNED      = 3'd3,
    ST_READ_DATA   = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TDC_SCALE = 1'b0,
    CFG_ADC_SCALE = 1'b1
  } cfg_idx_t;

  function automatic int bytes_round(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

  function automatic int bin_width(input int num_bins);
    return $clog2(num_bins + 2);
  endfunction

  function automatic int out_fields_width(input int time_bits, input int num_bins);
    return time_bits + 1 + bin_width(num_bins) + 2 * COUNT_W;
  endfunction

endpackage

`default_nettype wire

[rtl/per_channel_hit_interval_histogram_core.sv]
// Channel   Signals                          Transfer
// input     s_tvalid s_tready s_tdata s_tuser  one hit, end of event or read request
// result    m_tvalid m_tready m_tdata m_tuser  one result for each input except op 3
// config    cfg_we cfg_addr cfg_wdata          register write, no handshake
//
// One input transfer per cycle while s_tready is high; results pass stages s1 to s4 to the queue.
// Counts live in two RAMs updated by read, increment and write back,
// with the entry written in the previous cycle forwarded to a following read.
// After reset a clearing pass zeroes the bin and event RAMs, one entry a cycle, with s_tready low;
// the bin RAM holds NUM_CHANNELS * (NUM_BINS + 2) entries, 22440 with the default sizes.
// s_tready drops when queued results plus the up to four items in flight fill the 8-entry queue.
`default_nettype none

module per_channel_hit_interval_histogram_core import ihh_pkg::*; #(
  parameter int NUM_SIDES   = NUM_SIDES_DEF,
  parameter int NUM_PLANES  = NUM_PLANES_DEF,
  parameter int NUM_PADDLES = NUM_PADDLES_DEF,
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  localparam int BIN_W      = bin_width(NUM_BINS),
  localparam int IN_DATA_W  = bytes_round(SIDE_W + PLANE_W + PADDLE_W + TIME_BITS + BIN_W),
  localparam int OUT_DATA_W = bytes_round(out_fields_width(TIME_BITS, NUM_BINS))
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // side, plane, paddle_counter, hit_time, read_bin
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation, is_tdc
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // interval, bin_index, bin_count, event_count
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [OUT_USER_W-1:0] m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NUM_CHANNELS = 2 * NUM_SIDES * NUM_PLANES * NUM_PADDLES;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BIN_SLOTS    = NUM_BINS + 2;
  localparam int BIN_DEPTH    = NUM_CHANNELS * BIN_SLOTS;
  localparam int BIN_AW       = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
  localparam int IV_W         = TIME_BITS + 1;
  localparam int PROD_W       = TIME_BITS + SCALE_W;
  localparam int QX_W         = ((TIME_BITS > BIN_W) ? TIME_BITS : BIN_W) + 1;
  localparam int FIELDS_W     = out_fields_width(TIME_BITS, NUM_BINS);
  localparam int QUEUE_W      = STATUS_W + FIELDS_W;
  localparam int QCNT_W       = $clog2(OUT_QUEUE_DEPTH + 1);
  localparam int OFS_PLANE    = SIDE_W;
  localparam int OFS_PADDLE   = OFS_PLANE + PLANE_W;
  localparam int OFS_TIME     = OFS_PADDLE + PADDLE_W;
  localparam int OFS_RBIN     = OFS_TIME + TIME_BITS;

  logic [SCALE_W-1:0] tdc_bin_scale;
  logic [SCALE_W-1:0] adc_bin_scale;

  op_t                  in_op;
  logic                 in_is_tdc;
  logic [SIDE_W-1:0]    in_side;
  logic [PLANE_W-1:0]   in_plane;
  logic [PADDLE_W-1:0]  in_paddle;
  logic [TIME_BITS-1:0] in_time;
  logic [BIN_W-1:0]     in_read_bin;
  int                   ch_int;
  logic [CH_W-1:0]      in_ch;
  logic                 in_ch_ok;
  logic                 in_first;
  status_t              st0;
  logic                 push0;
  logic                 accept;
  logic                 hit_write;

  logic [NUM_CHANNELS-1:0] seen;
  logic [TIME_BITS-1:0]    lt_rdata;

  logic                 v1, v2, v3, v4;
  status_t              s1_st, s2_st, s3_st, s4_st;
  logic                 s1_push, s2_push, s3_push, s4_push;
  logic [CH_W-1:0]      s1_ch, s2_ch, s3_ch;
  logic [TIME_BITS-1:0] s1_time;
  logic                 s1_tdc;
  logic [BIN_W-1:0]     s1_rbin, s2_rbin, s3_rbin;
  logic [IV_W-1:0]      s2_diff, s3_diff, s4_diff;
  logic [SCALE_W-1:0]   s2_scale;
  logic [BIN_AW-1:0]    s2_base, s3_base;
  logic [PROD_W-1:0]    s3_prod;
  logic [BIN_W-1:0]     s4_bin;
  logic                 s4_range;

  logic [IV_W-1:0]      diff1;
  logic [PROD_W-1:0]    prod2;
  logic [QX_W-1:0]      q3;
  logic [BIN_W-1:0]     calc_bin3;
  logic [BIN_W-1:0]     bin3;
  logic                 range3;
  logic [BIN_AW-1:0]    bins_addr3;

  logic                 bins_rd, bins_inc, bins_busy;
  logic                 ev_rd, ev_inc, ev_busy;
  logic [COUNT_W-1:0]   bins_value, ev_value;

  logic [IV_W-1:0]      out_interval;
  logic [BIN_W-1:0]     out_bin_index;
  logic [COUNT_W-1:0]   out_bin_count;
  logic [COUNT_W-1:0]   out_event_count;
  logic [QUEUE_W-1:0]   q_in, q_out;
  logic [QCNT_W-1:0]    q_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      tdc_bin_scale <= TDC_SCALE_RESET;
      adc_bin_scale <= ADC_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TDC_SCALE: tdc_bin_scale <= cfg_wdata;
        CFG_ADC_SCALE: adc_bin_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_op       = op_t'(s_tuser[OP_W-1:0]);
  assign in_is_tdc   = s_tuser[OP_W];
  assign in_side     = s_tdata[0 +: SIDE_W];
  assign in_plane    = s_tdata[OFS_PLANE +: PLANE_W];
  assign in_paddle   = s_tdata[OFS_PADDLE +: PADDLE_W];
  assign in_time     = s_tdata[OFS_TIME +: TIME_BITS];
  assign in_read_bin = s_tdata[OFS_RBIN +: BIN_W];

  always_comb begin
    ch_int = ((int'(in_is_tdc) * NUM_SIDES + int'(in_side)) * NUM_PLANES
              + int'(in_plane)) * NUM_PADDLES + int'(in_paddle) - 1;
    in_ch    = CH_W'(ch_int);
    in_ch_ok = (int'(in_side) < NUM_SIDES) && (int'(in_plane) < NUM_PLANES)
               && (in_paddle != '0) && (int'(in_paddle) <= NUM_PADDLES);
    in_first = !seen[in_ch];
    push0    = 1'b1;
    st0      = ST_EVENT_END;
    case (in_op)
      OP_END_EVENT: st0 = ST_EVENT_END;
      OP_HIT: begin
        if (!in_ch_ok) begin
          st0 = ST_BAD_CHANNEL;
        end else if (in_first) begin
          st0 = ST_FIRST_HIT;
        end else begin
          st0 = ST_BINNED;
        end
      end
      OP_READ: st0 = in_ch_ok ? ST_READ_DATA : ST_BAD_CHANNEL;
      default: push0 = 1'b0;
    endcase
  end

  assign s_tready = !bins_busy && !ev_busy
                    && (int'(q_level) + int'(v1) + int'(v2) + int'(v3) + int'(v4)
                        < OUT_QUEUE_DEPTH);
  assign accept    = s_tvalid && s_tready;
  assign hit_write = accept && (in_op == OP_HIT) && in_ch_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept && in_op == OP_END_EVENT) begin
      seen <= '0;
    end else if (hit_write) begin
      seen[in_ch] <= 1'b1;
    end
  end

  // Every hit on a valid channel stores its time; the read returns the time of the previous hit there.
  ihh_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(NUM_CHANNELS)
  ) u_last_time (
    .clk  (clk),
    .we   (hit_write),
    .waddr(in_ch),
    .wdata(in_time),
    .re   (hit_write),
    .raddr(in_ch),
    .rdata(lt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign diff1 = {1'b0, s1_time} - {1'b0, lt_rdata};
  assign prod2 = PROD_W'(s2_diff[TIME_BITS-1:0]) * PROD_W'(s2_scale);

  always_comb begin
    q3 = QX_W'(s3_prod[SCALE_SHIFT +: TIME_BITS]);
    if (s3_diff[IV_W-1]) begin
      calc_bin3 = '0;
    end else if (q3 >= QX_W'(NUM_BINS)) begin
      calc_bin3 = BIN_W'(NUM_BINS + 1);
    end else begin
      calc_bin3 = BIN_W'(q3 + QX_W'(1));
    end
    bin3       = (s3_st == ST_READ_DATA) ? s3_rbin : calc_bin3;
    range3     = (int'(s3_rbin) < BIN_SLOTS);
    bins_addr3 = s3_base + BIN_AW'(bin3);
  end

  always_ff @(posedge clk) begin
    s1_st    <= st0;
    s1_push  <= push0;
    s1_ch    <= in_ch;
    s1_time  <= in_time;
    s1_tdc   <= in_is_tdc;
    s1_rbin  <= in_read_bin;

    s2_st    <= s1_st;
    s2_push  <= s1_push;
    s2_ch    <= s1_ch;
    s2_rbin  <= s1_rbin;
    s2_diff  <= diff1;
    s2_scale <= s1_tdc ? tdc_bin_scale : adc_bin_scale;
    s2_base  <= BIN_AW'(int'(s1_ch) * BIN_SLOTS);

    s3_st    <= s2_st;
    s3_push  <= s2_push;
    s3_ch    <= s2_ch;
    s3_rbin  <= s2_rbin;
    s3_diff  <= s2_diff;
    s3_base  <= s2_base;
    s3_prod  <= prod2;

    s4_st    <= s3_st;
    s4_push  <= s3_push;
    s4_diff  <= s3_diff;
    s4_bin   <= bin3;
    s4_range <= range3;
  end

  assign bins_rd  = v3 && ((s3_st == ST_BINNED) || (s3_st == ST_READ_DATA && range3));
  assign bins_inc = v4 && (s4_st == ST_BINNED);
  assign ev_rd    = v3 && ((s3_st == ST_FIRST_HIT) || (s3_st == ST_READ_DATA));
  assign ev_inc   = v4 && (s4_st == ST_FIRST_HIT);

  ihh_count_bank #(
    .DEPTH(BIN_DEPTH)
  ) u_bins (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (bins_rd),
    .rd_addr(bins_addr3),
    .inc    (bins_inc),
    .value  (bins_value),
    .busy   (bins_busy)
  );

  ihh_count_bank #(
    .DEPTH(NUM_CHANNELS)
  ) u_events (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (ev_rd),
    .rd_addr(s3_ch),
    .inc    (ev_inc),
    .value  (ev_value),
    .busy   (ev_busy)
  );

  assign out_interval    = (s4_st == ST_BINNED) ? s4_diff : '0;
  assign out_bin_index   = (s4_st == ST_BINNED) ? s4_bin : '0;
  assign out_bin_count   = (s4_st == ST_READ_DATA && s4_range) ? bins_value : '0;
  assign out_event_count = (s4_st == ST_READ_DATA) ? ev_value : '0;
  assign q_in = {s4_st, out_event_count, out_bin_count, out_bin_index, out_interval};

  ihh_out_queue #(
    .WIDTH(QUEUE_W),
    .DEPTH(OUT_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (v4 && s4_push),
    .push_data(q_in),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (q_out),
    .level    (q_level)
  );

  assign m_tdata = OUT_DATA_W'(q_out[FIELDS_W-1:0]);
  assign m_tuser = q_out[QUEUE_W-1 -: STATUS_W];

endmodule

`default_nettype wire

[rtl/ihh_ram.sv]
`default_nettype none

module ihh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // A read and a write of the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/ihh_count_bank.sv]
`default_nettype none

module ihh_count_bank import ihh_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  input  logic               inc,
  output logic [COUNT_W-1:0] value,
  output logic               busy
);

  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      hold_addr;
  logic [COUNT_W-1:0] rdata;
  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  logic [COUNT_W-1:0] fwd_data;
  logic [COUNT_W-1:0] inc_data;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;

  // The entry written in the previous cycle was missed by this read.
  assign value    = (fwd_valid && fwd_addr == hold_addr) ? fwd_data : rdata;
  assign inc_data = (value == COUNT_MAX) ? value : value + COUNT_W'(1);

  assign ram_we    = busy || inc;
  assign ram_waddr = busy ? clr_addr : hold_addr;
  assign ram_wdata = busy ? '0 : inc_data;

  ihh_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= inc && !busy;
    end
  end

  always_ff @(posedge clk) begin
    hold_addr <= rd_addr;
    fwd_addr  <= hold_addr;
    fwd_data  <= inc_data;
  end

endmodule

`default_nettype wire

[rtl/ihh_out_queue.sv]
`default_nettype none

module ihh_out_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data,
  output logic [CW-1:0]    level
);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             pop;

  assign out_valid = (level != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      level <= level + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

[rtl/ihh_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module ihh_checker import ihh_pkg::*; #(
  parameter int NUM_BINS  = NUM_BINS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int BIN_W      = bin_width(NUM_BINS),
  localparam int IV_W       = TIME_BITS + 1,
  localparam int OUT_DATA_W = bytes_round(out_fields_width(TIME_BITS, NUM_BINS))
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  localparam int CNT_LO = IV_W + BIN_W;

  `ASSERT_CLK_NORST(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")

  `ASSERT_CLK(a_hold_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  `ASSERT_CLK(a_interval_zero, m_tvalid && m_tuser != ST_BINNED |-> m_tdata[CNT_LO-1:0] == '0, "interval fields set outside a binned result")

  `ASSERT_CLK(a_counts_zero, m_tvalid && m_tuser != ST_READ_DATA |-> m_tdata[CNT_LO +: 2*COUNT_W] == '0, "count fields set outside a read result")

  `ASSERT_CLK(a_bin_range, m_tvalid && m_tuser == ST_BINNED |-> m_tdata[IV_W +: BIN_W] <= BIN_W'(NUM_BINS + 1), "bin index beyond overflow bin")

endmodule

bind per_channel_hit_interval_histogram_core ihh_checker #(
  .NUM_BINS (NUM_BINS),
  .TIME_BITS(TIME_BITS)
) u_ihh_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire

[sim/tb_per_channel_hit_interval_histogram_core.sv]
`timescale 1ns / 100ps
`default_nettype none

module tb_per_channel_hit_interval_histogram_core;
  import ihh_pkg::*;

  localparam int NUM_CH = 2 * NUM_SIDES_DEF * NUM_PLANES_DEF * NUM_PADDLES_DEF;
  localparam int SLOTS = NUM_BINS_DEF + 2;
  localparam int BIN_W = bin_width(NUM_BINS_DEF);
  localparam int IV_W = TIME_BITS_DEF + 1;
  localparam int IN_DATA_W =
    bytes_round(SIDE_W + PLANE_W + PADDLE_W + TIME_BITS_DEF + BIN_W);
  localparam int OUT_DATA_W = bytes_round(out_fields_width(TIME_BITS_DEF, NUM_BINS_DEF));
  localparam int BI_LSB = IV_W;
  localparam int BC_LSB = BI_LSB + BIN_W;
  localparam int EC_LSB = BC_LSB + COUNT_W;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [OP_W-1:0] op;
    bit is_tdc;
    bit [SIDE_W-1:0] side;
    bit [PLANE_W-1:0] plane;
    bit [PADDLE_W-1:0] paddle;
    bit [TIME_BITS_DEF-1:0] hit_time;
    bit [BIN_W-1:0] read_bin;
  } hit_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IV_W-1:0] interval;
    logic [BIN_W-1:0] bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] event_count;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  hit_item_t hit_stream[$];
  hist_result_t pending_results[$];
  hit_item_t cur_item;
  bit took = 1'b0;

  int gap_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int accepted_items = 0;
  int checked_results = 0;
  int n_binned = 0;
  int n_first = 0;
  int n_reads = 0;
  int n_bad = 0;
  int n_ends = 0;

  int unsigned tdc_scale = TDC_SCALE_RESET;
  int unsigned adc_scale = ADC_SCALE_RESET;
  bit [TIME_BITS_DEF-1:0] last_time[NUM_CH];
  bit seen_in_event[NUM_CH];
  int unsigned bin_counts[NUM_CH * SLOTS];
  int unsigned event_counts[NUM_CH];

  per_channel_hit_interval_histogram_core u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic update_histograms(input hit_item_t it);
    hist_result_t r;
    int unsigned ch;
    int unsigned slot;
    longint diff;
    longint unsigned q;
    int unsigned b;
    int unsigned scale;
    r = '0;
    if (it.op == OP_UNUSED) return;
    if (it.op == OP_END_EVENT) begin
      foreach (seen_in_event[i]) seen_in_event[i] = 1'b0;
      r.status = ST_EVENT_END;
    end else if (it.side >= NUM_SIDES_DEF || it.plane >= NUM_PLANES_DEF ||
                 it.paddle < 1 || it.paddle > NUM_PADDLES_DEF) begin
      r.status = ST_BAD_CHANNEL;
    end else begin
      ch = ((int'(it.is_tdc) * NUM_SIDES_DEF + int'(it.side)) * NUM_PLANES_DEF
            + int'(it.plane)) * NUM_PADDLES_DEF + int'(it.paddle) - 1;
      if (it.op == OP_READ) begin
        r.status = ST_READ_DATA;
        if (it.read_bin < SLOTS) r.bin_count = bin_counts[ch * SLOTS + it.read_bin];
        r.event_count = event_counts[ch];
      end else if (!seen_in_event[ch]) begin
        seen_in_event[ch] = 1'b1;
        last_time[ch] = it.hit_time;
        if (event_counts[ch] != COUNT_MAX) event_counts[ch]++;
        r.status = ST_FIRST_HIT;
      end else begin
        diff = longint'(it.hit_time) - longint'(last_time[ch]);
        scale = it.is_tdc ? tdc_scale : adc_scale;
        if (diff < 0) begin
          b = 0;
        end else begin
          q = (longint'(diff) * scale) >> SCALE_SHIFT;
          b = (q >= NUM_BINS_DEF) ? NUM_BINS_DEF + 1 : int'(q) + 1;
        end
        slot = ch * SLOTS + b;
        if (bin_counts[slot] != COUNT_MAX) bin_counts[slot]++;
        last_time[ch] = it.hit_time;
        r.status = ST_BINNED;
        r.interval = diff[IV_W-1:0];
        r.bin_index = b[BIN_W-1:0];
      end
    end
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      update_histograms(cur_item);
      accepted_items++;
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took) begin
      took = 1'b0;
      if (hit_stream.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        cur_item = hit_stream.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'({cur_item.read_bin, cur_item.hit_time, cur_item.paddle,
                               cur_item.plane, cur_item.side});
        s_tuser <= {cur_item.is_tdc, cur_item.op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void check_field(input string name, input longint exp_v,
                                      input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    hist_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result, status %0d", m_tuser);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        checked_results++;
        check_field("status", e.status, m_tuser);
        check_field("interval", $signed(e.interval), $signed(m_tdata[IV_W-1:0]));
        check_field("bin_index", e.bin_index, m_tdata[BI_LSB +: BIN_W]);
        check_field("bin_count", e.bin_count, m_tdata[BC_LSB +: COUNT_W]);
        check_field("event_count", e.event_count, m_tdata[EC_LSB +: COUNT_W]);
        case (e.status)
          ST_EVENT_END: n_ends++;
          ST_BAD_CHANNEL: n_bad++;
          ST_FIRST_HIT: n_first++;
          ST_BINNED: n_binned++;
          default: n_reads++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input bit tdc, input bit sd,
                           input bit [PLANE_W-1:0] pl, input bit [PADDLE_W-1:0] pd,
                           input bit [TIME_BITS_DEF-1:0] tm, input bit [BIN_W-1:0] rb);
    hit_item_t it;
    it.op = op;
    it.is_tdc = tdc;
    it.side = sd;
    it.plane = pl;
    it.paddle = pd;
    it.hit_time = tm;
    it.read_bin = rb;
    hit_stream.push_back(it);
  endtask

  task automatic wait_drained();
    while (hit_stream.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TDC_SCALE) tdc_scale = value & 16'hFFFF;
    else adc_scale = value & 16'hFFFF;
  endtask

  task automatic run_phase(input int n, input int gap, input int stall,
                           input int unsigned tdc_s, input int unsigned adc_s,
                           input bit write_cfg);
    int made;
    int nch;
    int nhits;
    int k;
    int j;
    int kind;
    int unsigned scale;
    longint span;
    logic [OP_W-1:0] op;
    bit [TIME_BITS_DEF-1:0] delta;
    bit ev_tdc[4];
    bit ev_side[4];
    bit [PLANE_W-1:0] ev_plane[4];
    bit [PADDLE_W-1:0] ev_pad[4];
    bit [TIME_BITS_DEF-1:0] ev_time[4];
    bit ev_on[4];
    wait_drained();
    if (write_cfg) begin
      write_reg(CFG_TDC_SCALE, tdc_s);
      write_reg(CFG_ADC_SCALE, adc_s);
    end
    gap_pct = gap;
    stall_pct = stall;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        op = $urandom_range(0, 3);
        push_item(op, $urandom, $urandom, $urandom_range(0, 7), $urandom_range(0, 255),
                  $urandom, $urandom_range(0, 127));
        if (op != OP_UNUSED) made++;
      end else begin
        nch = $urandom_range(1, 4);
        for (k = 0; k < nch; k++) begin
          ev_tdc[k] = $urandom;
          ev_side[k] = $urandom;
          ev_plane[k] = $urandom_range(0, NUM_PLANES_DEF - 1);
          ev_pad[k] = $urandom_range(1, NUM_PADDLES_DEF);
          ev_on[k] = 1'b0;
        end
        nhits = $urandom_range(2, 12);
        for (j = 0; j < nhits; j++) begin
          k = $urandom_range(0, nch - 1);
          scale = ev_tdc[k] ? tdc_scale : adc_scale;
          span = (scale == 0) ? 4096 : (longint'(SLOTS) << SCALE_SHIFT) / scale;
          if (span > 20'hFFFFF) span = 20'hFFFFF;
          if (span < 1) span = 1;
          if (!ev_on[k]) begin
            ev_time[k] = $urandom;
          end else begin
            kind = $urandom_range(0, 99);
            if (kind < 60) delta = $urandom_range(0, span);
            else if (kind < 70) delta = '0;
            else if (kind < 80) delta = -TIME_BITS_DEF'($urandom_range(1, span));
            else if (kind < 90) delta = $urandom;
            else delta = $urandom_range(0, 15);
            ev_time[k] = ev_time[k] + delta;
          end
          ev_on[k] = 1'b1;
          push_item(OP_HIT, ev_tdc[k], ev_side[k], ev_plane[k], ev_pad[k], ev_time[k], '0);
          made++;
        end
        for (j = $urandom_range(0, 3); j > 0; j--) begin
          k = $urandom_range(0, nch - 1);
          push_item(OP_READ, ev_tdc[k], ev_side[k], ev_plane[k], ev_pad[k], $urandom,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS, 127)
                                                : $urandom_range(0, SLOTS - 1));
          made++;
        end
        if ($urandom_range(0, 9) != 0) begin
          push_item(OP_END_EVENT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default scales: TDC channel top of every field, ADC channel at the bottom.
    push_item(OP_READ, 1'b0, 1'b0, 3'd0, 8'd1, '0, 7'd0);
    push_item(OP_HIT, 1'b1, 1'b1, 3'd4, 8'd11, 20'd0, '0);
    push_item(OP_HIT, 1'b1, 1'b1, 3'd4, 8'd11, 20'd0, '0);
    push_item(OP_HIT, 1'b1, 1'b1, 3'd4, 8'd11, 20'hFFFFF, '0);
    push_item(OP_HIT, 1'b1, 1'b1, 3'd4, 8'd11, 20'd0, '0);
    push_item(OP_HIT, 1'b0, 1'b0, 3'd0, 8'd1, 20'd100, '0);
    push_item(OP_HIT, 1'b0, 1'b0, 3'd0, 8'd1, 20'd180, '0);
    push_item(OP_HIT, 1'b0, 1'b0, 3'd0, 8'd1, 20'd8180, '0);
    push_item(OP_HIT, 1'b1, 1'b0, 3'd0, 8'd0, 20'd5, '0);
    push_item(OP_HIT, 1'b1, 1'b0, 3'd0, 8'd12, 20'd5, '0);
    push_item(OP_HIT, 1'b0, 1'b1, 3'd2, 8'd255, 20'd5, '0);
    push_item(OP_HIT, 1'b0, 1'b0, 3'd5, 8'd3, 20'd5, '0);
    push_item(OP_READ, 1'b1, 1'b1, 3'd7, 8'd3, '0, 7'd1);
    push_item(OP_UNUSED, 1'b1, 1'b1, 3'd4, 8'd11, 20'hFFFFF, 7'h7F);
    push_item(OP_READ, 1'b1, 1'b1, 3'd4, 8'd11, '0, 7'd101);
    push_item(OP_READ, 1'b1, 1'b1, 3'd4, 8'd11, '0, 7'd0);
    push_item(OP_READ, 1'b1, 1'b1, 3'd4, 8'd11, '0, 7'd1);
    push_item(OP_READ, 1'b1, 1'b1, 3'd4, 8'd11, '0, 7'd127);
    push_item(OP_READ, 1'b0, 1'b0, 3'd0, 8'd1, '0, 7'd2);
    push_item(OP_END_EVENT, 1'b0, 1'b0, 3'd0, 8'd0, '0, '0);
    push_item(OP_HIT, 1'b1, 1'b1, 3'd4, 8'd11, 20'd5, '0);
    push_item(OP_READ, 1'b1, 1'b1, 3'd4, 8'd11, '0, 7'd102);
    push_item(OP_READ, 1'b0, 1'b1, 3'd1, 8'd0, '0, 7'd50);

    run_phase(220, 0, 0, TDC_SCALE_RESET, ADC_SCALE_RESET, 1'b0);
    run_phase(230, 50, 0, 16'hFFFF, 16'hFFFF, 1'b1);
    run_phase(230, 0, 50, 0, 0, 1'b1);
    run_phase(230, 36, 36, 1, 1, 1'b1);
    run_phase(230, 0, 0, $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1);
    run_phase(230, 50, 0, 6553, 200, 1'b1);
    run_phase(230, 0, 50, 16'hFFFF, 0, 1'b1);
    run_phase(230, 36, 36, TDC_SCALE_RESET, ADC_SCALE_RESET, 1'b1);

    wait_drained();
    $display("Run covered %0d input transfers and %0d checked results over eight scale settings.",
             accepted_items, checked_results);
    $display("Results: %0d binned, %0d first hits, %0d reads, %0d bad channels, %0d event ends.",
             n_binned, n_first, n_reads, n_bad, n_ends);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/ihh_pkg.sv
rtl/ihh_ram.sv
rtl/ihh_count_bank.sv
rtl/ihh_out_queue.sv
rtl/per_channel_hit_interval_histogram_core.sv
rtl/ihh_checker.sv
sim/tb_per_channel_hit_interval_histogram_core.sv
